/* rtl/rtcm_pkg.sv */
// ----------------------------------------------------------------------------
// Radial texture column mapper package
// Shared widths, register indexes, jitter codes and pipeline depth figures.
// ----------------------------------------------------------------------------
`default_nettype none

package rtcm_pkg;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_TILING_FACTOR = 3'd2,
    CFG_OFFSET_Q8     = 3'd3,
    CFG_NOISE_ENABLE  = 3'd4
  } cfg_idx_e;

  // Jitter codes; the fourth code acts as plus one.
  localparam logic [1:0] JitMinus = 2'd0;
  localparam logic [1:0] JitHold  = 2'd1;

  // Field widths.
  localparam int CoordW = 12;
  localparam int DimW   = 13;
  localparam int TileW  = 8;
  localparam int OffW   = 20;
  localparam int TexW   = 12;

  // Datapath widths.
  localparam int AbsW      = 14;               // |2c - W| in half pixels
  localparam int SqW       = 2 * AbsW;         // one square
  localparam int SqrtSteps = 23;               // root bits
  localparam int SqVW      = 2 * SqrtSteps;    // (dx^2 + dy^2) << 16, padded
  localparam int SqRemW    = SqrtSteps + 1;
  localparam int WtW       = DimW + TileW;
  localparam int OhW       = OffW + DimW;
  localparam int ProdW     = WtW + SqrtSteps;
  localparam int NumW      = ProdW + 4;        // full numerator
  localparam int QuoW      = NumW - 12;        // numerator over 4096
  localparam int DivSteps  = QuoW;
  localparam int ModSteps  = QuoW;
  localparam int HalfW     = DimW - 1;

  // Accept to result, in cycles.
  localparam int Latency = 4 + SqrtSteps + 2 + DivSteps + 1 + ModSteps + 1;

endpackage

`default_nettype wire

/* rtl/radial_texture_column_mapper_top.sv */
// ----------------------------------------------------------------------------
// Radial texture column mapper
// Maps a screen pixel to a texture column of a radial effect, one pixel per
// clock, through a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
// A pixel beat is taken at every rising edge where start_i is high and busy_o
// is low. The datapath never holds off input, so busy_o stays low and a new
// pixel can enter on every clock.
// Each beat gives one texture column on texture_col_o, marked by done_o for a
// single cycle. Results leave in the order the pixels came in. The receiver
// cannot stall the block. The latency is set by the digit-serial units laid
// out as pipeline stages: the 23-step square root, the 36-step division by
// the screen height and the 36-step reduction modulo half the width, one
// result bit per stage.
// Throughput is one pixel per clock.
// Configuration registers are to be written through cfg_we_i, cfg_index_i
// and cfg_wdata_i only while no pixel is in flight; the block does not
// enforce this. They take effect immediately. Reset (rst_ni low) clears
// every stage valid bit, so no stray done_o appears, and restores the
// registers to 640 by 480, tiling one, offset zero and jitter off.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_texture_column_mapper_top #(
  parameter int MAX_DIM = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [rtcm_pkg::CoordW-1:0]       pixel_col_i,
  input  logic [rtcm_pkg::CoordW-1:0]       pixel_row_i,
  input  logic [1:0]                        col_jitter_i,
  input  logic [1:0]                        row_jitter_i,
  output logic                              done_o,
  output logic [rtcm_pkg::TexW-1:0]         texture_col_o,
  input  logic                              cfg_we_i,
  input  logic [rtcm_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rtcm_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  import rtcm_pkg::*;

  localparam logic [DimW+1:0] MaxDim = (DimW+2)'(MAX_DIM);

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [DimW-1:0]  scr_w_q, scr_h_q;
  logic [TileW-1:0] tile_q;
  logic [OffW-1:0]  offset_q;
  logic             noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q  <= DimW'(640);
      scr_h_q  <= DimW'(480);
      tile_q   <= TileW'(1);
      offset_q <= '0;
      noise_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SCREEN_WIDTH:  scr_w_q  <= cfg_wdata_i[DimW-1:0];
        CFG_SCREEN_HEIGHT: scr_h_q  <= cfg_wdata_i[DimW-1:0];
        CFG_TILING_FACTOR: tile_q   <= cfg_wdata_i[TileW-1:0];
        CFG_OFFSET_Q8:     offset_q <= cfg_wdata_i;
        CFG_NOISE_ENABLE:  noise_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Dimensions clamped to MAX_DIM; a zero height counts as one.
  logic [DimW-1:0]  w_eff, h_clamp, h_eff;
  logic [HalfW-1:0] half_w;

  assign w_eff   = ({2'b00, scr_w_q} > MaxDim) ? MaxDim[DimW-1:0] : scr_w_q;
  assign h_clamp = ({2'b00, scr_h_q} > MaxDim) ? MaxDim[DimW-1:0] : scr_h_q;
  assign h_eff   = (h_clamp == '0) ? DimW'(1) : h_clamp;
  assign half_w  = w_eff[DimW-1:1];

  // Products of static registers, refreshed every cycle. They settle long
  // before a pixel entering after a register write reaches them.
  logic [WtW-1:0] wt_q;
  logic [OhW-1:0] oh_q;

  always_ff @(posedge clk_i) begin
    wt_q <= WtW'(w_eff) * WtW'(tile_q);
    oh_q <= OhW'(offset_q) * OhW'(h_eff);
  end

  // --------------------------------------------------------------------------
  // Stage 0: input capture.
  // --------------------------------------------------------------------------
  logic              s0_vld_q;
  logic [CoordW-1:0] s0_col_q, s0_row_q;
  logic [1:0]        s0_cj_q, s0_rj_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_vld_q <= 1'b0;
    else         s0_vld_q <= start_i && !busy_o;
  end

  always_ff @(posedge clk_i) begin
    s0_col_q <= pixel_col_i;
    s0_row_q <= pixel_row_i;
    s0_cj_q  <= col_jitter_i;
    s0_rj_q  <= row_jitter_i;
  end

  // --------------------------------------------------------------------------
  // Stage 1: jitter with wrap, then the centre distances in half pixels.
  // --------------------------------------------------------------------------
  function automatic logic signed [DimW+1:0] jitter_coord(
    input logic [CoordW-1:0] k,
    input logic [DimW-1:0]   n,
    input logic [1:0]        sel,
    input logic              en
  );
    logic signed [DimW+1:0] ks, nm1;
    ks  = $signed({3'b000, k});
    nm1 = $signed({2'b00, n}) - 15'sd1;
    if (!en || sel == JitHold)  jitter_coord = ks;
    else if (sel == JitMinus)   jitter_coord = (k == '0) ? nm1 : ks - 15'sd1;
    else                        jitter_coord = (ks == nm1) ? 15'sd0 : ks + 15'sd1;
  endfunction

  logic signed [DimW+1:0] c_s, r_s;
  logic signed [DimW+2:0] dx_s, dy_s, dx_neg, dy_neg;
  logic                   s1_vld_q;
  logic [AbsW-1:0]        s1_dx_q, s1_dy_q;

  always_comb begin
    c_s    = jitter_coord(s0_col_q, w_eff, s0_cj_q, noise_q);
    r_s    = jitter_coord(s0_row_q, h_eff, s0_rj_q, noise_q);
    dx_s   = $signed({c_s, 1'b0}) - $signed({3'b000, w_eff});
    dy_s   = $signed({r_s, 1'b0}) - $signed({3'b000, h_eff});
    dx_neg = -dx_s;
    dy_neg = -dy_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= s0_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s1_dx_q <= dx_s[DimW+2] ? dx_neg[AbsW-1:0] : dx_s[AbsW-1:0];
    s1_dy_q <= dy_s[DimW+2] ? dy_neg[AbsW-1:0] : dy_s[AbsW-1:0];
  end

  // --------------------------------------------------------------------------
  // Stage 2: squares. Stage 3: sum, scaled by 2^16 for 8 root fraction bits.
  // --------------------------------------------------------------------------
  logic           s2_vld_q;
  logic [SqW-1:0] s2_dx2_q, s2_dy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else         s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    s2_dx2_q <= SqW'(s1_dx_q) * SqW'(s1_dx_q);
    s2_dy2_q <= SqW'(s1_dy_q) * SqW'(s1_dy_q);
  end

  logic              sq_vld_q  [SqrtSteps+1];
  logic [SqVW-1:0]   sq_v_q    [SqrtSteps+1];
  logic [SqrtSteps-1:0] sq_root_q [SqrtSteps+1];
  logic [SqRemW-1:0] sq_rem_q  [SqrtSteps+1];
  logic [SqW:0]      sq_sum;

  assign sq_sum = {1'b0, s2_dx2_q} + {1'b0, s2_dy2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_vld_q[0] <= 1'b0;
    else         sq_vld_q[0] <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    sq_v_q[0]    <= SqVW'({sq_sum, 16'h0000});
    sq_root_q[0] <= '0;
    sq_rem_q[0]  <= '0;
  end

  // --------------------------------------------------------------------------
  // Square root, one root bit per stage.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    logic [SqRemW+1:0] trial, test, diff;
    logic              ge;

    assign trial = {sq_rem_q[i], sq_v_q[i][SqVW-1 -: 2]};
    assign test  = {1'b0, sq_root_q[i], 2'b01};
    assign ge    = trial >= test;
    assign diff  = trial - test;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sq_vld_q[i+1] <= 1'b0;
      else         sq_vld_q[i+1] <= sq_vld_q[i];
    end

    always_ff @(posedge clk_i) begin
      sq_v_q[i+1]    <= {sq_v_q[i][SqVW-3:0], 2'b00};
      sq_root_q[i+1] <= {sq_root_q[i][SqrtSteps-2:0], ge};
      sq_rem_q[i+1]  <= ge ? diff[SqRemW-1:0] : trial[SqRemW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Scaling: p = W*T*rq, then num = 5*p + 16*O*H. Only num / 4096 is kept.
  // --------------------------------------------------------------------------
  logic             p_vld_q;
  logic [ProdW-1:0] p_q;
  logic [NumW-1:0]  num_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_vld_q <= 1'b0;
    else         p_vld_q <= sq_vld_q[SqrtSteps];
  end

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(wt_q) * ProdW'(sq_root_q[SqrtSteps]);
  end

  assign num_full = NumW'({p_q, 2'b00}) + NumW'(p_q) + NumW'({oh_q, 4'h0});

  // --------------------------------------------------------------------------
  // Division by the height, one quotient bit per stage.
  // --------------------------------------------------------------------------
  logic            dv_vld_q [DivSteps+1];
  logic [QuoW-1:0] dv_n_q   [DivSteps+1];
  logic [QuoW-1:0] dv_q_q   [DivSteps+1];
  logic [DimW-1:0] dv_r_q   [DivSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_vld_q[0] <= 1'b0;
    else         dv_vld_q[0] <= p_vld_q;
  end

  always_ff @(posedge clk_i) begin
    dv_n_q[0] <= num_full[NumW-1:NumW-QuoW];
    dv_q_q[0] <= '0;
    dv_r_q[0] <= '0;
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    logic [DimW:0] trial, diff;
    logic          ge;

    assign trial = {dv_r_q[i], dv_n_q[i][QuoW-1]};
    assign ge    = trial >= {1'b0, h_eff};
    assign diff  = trial - {1'b0, h_eff};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_vld_q[i+1] <= 1'b0;
      else         dv_vld_q[i+1] <= dv_vld_q[i];
    end

    always_ff @(posedge clk_i) begin
      dv_n_q[i+1] <= {dv_n_q[i][QuoW-2:0], 1'b0};
      dv_q_q[i+1] <= {dv_q_q[i][QuoW-2:0], ge};
      dv_r_q[i+1] <= ge ? diff[DimW-1:0] : trial[DimW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Folding: an index above half the width becomes ((idx - 1) mod half) + 1.
  // The modulo runs one bit per stage; the index itself rides along.
  // --------------------------------------------------------------------------
  logic             md_vld_q [ModSteps+1];
  logic [QuoW-1:0]  md_n_q   [ModSteps+1];
  logic [HalfW-1:0] md_r_q   [ModSteps+1];
  logic [TexW-1:0]  md_lo_q  [ModSteps+1];
  logic             md_gt_q  [ModSteps+1];
  logic [QuoW-1:0]  idx;

  assign idx = dv_q_q[DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) md_vld_q[0] <= 1'b0;
    else         md_vld_q[0] <= dv_vld_q[DivSteps];
  end

  always_ff @(posedge clk_i) begin
    md_n_q[0]  <= idx - QuoW'(1);
    md_r_q[0]  <= '0;
    md_lo_q[0] <= idx[TexW-1:0];
    md_gt_q[0] <= idx > QuoW'(half_w);
  end

  for (genvar i = 0; i < ModSteps; i++) begin : g_mod
    logic [HalfW:0] trial, diff;
    logic           ge;

    assign trial = {md_r_q[i], md_n_q[i][QuoW-1]};
    assign ge    = trial >= {1'b0, half_w};
    assign diff  = trial - {1'b0, half_w};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) md_vld_q[i+1] <= 1'b0;
      else         md_vld_q[i+1] <= md_vld_q[i];
    end

    always_ff @(posedge clk_i) begin
      md_n_q[i+1]  <= {md_n_q[i][QuoW-2:0], 1'b0};
      md_r_q[i+1]  <= ge ? diff[HalfW-1:0] : trial[HalfW-1:0];
      md_lo_q[i+1] <= md_lo_q[i];
      md_gt_q[i+1] <= md_gt_q[i];
    end
  end

  // --------------------------------------------------------------------------
  // Output register. A half width of zero forces the column to zero.
  // --------------------------------------------------------------------------
  logic            out_vld_q;
  logic [TexW-1:0] out_col_d, out_col_q;

  always_comb begin
    if (half_w == '0)                 out_col_d = '0;
    else if (md_gt_q[ModSteps])       out_col_d = TexW'(md_r_q[ModSteps]) + TexW'(1);
    else                              out_col_d = md_lo_q[ModSteps];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else         out_vld_q <= md_vld_q[ModSteps];
  end

  always_ff @(posedge clk_i) begin
    out_col_q <= out_col_d;
  end

  assign done_o        = out_vld_q;
  assign texture_col_o = out_col_q;

endmodule

`default_nettype wire

/* rtl/rtcm_checker.sv */
// ----------------------------------------------------------------------------
// Radial texture column mapper checker
// Port-level timing checks, attached to the top level by a bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rtcm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  import rtcm_pkg::*;

  // The pipeline never refuses a pixel.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy_o raised");

  // Every accepted beat yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency done_o)
    else $error("result missing at expected latency");

  // No result appears without a beat accepted the latency earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##Latency !done_o)
    else $error("result without matching input beat");

endmodule

bind radial_texture_column_mapper_top rtcm_checker u_rtcm_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Radial texture column mapper testbench
// Drives pixel beats with random idle gaps over several register settings,
// predicts each texture column in plain integer arithmetic and checks every
// done_o beat in order against the predicted column.
// ----------------------------------------------------------------------------
`default_nettype none

// Holds the predicted texture columns in arrival order and checks results.
class tex_col_board;
  int unsigned pending_cols[$];
  int          mismatches;

  function void note_pixel(int unsigned col);
    pending_cols.push_back(col);
  endfunction

  // Returns a message when the result is wrong, or an empty string.
  function string check_col(int unsigned got);
    int unsigned want;
    if (pending_cols.size() == 0) return $sformatf("unexpected column %0d", got);
    want = pending_cols.pop_front();
    if (want != got) return $sformatf("texture_col got %0d want %0d", got, want);
    return "";
  endfunction
endclass

module testbench;
  import rtcm_pkg::*;

  localparam int MaxDim    = 4096;
  localparam int StallMax  = 20000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [CoordW-1:0]   pixel_col_i = '0;
  logic [CoordW-1:0]   pixel_row_i = '0;
  logic [1:0]          col_jitter_i = '0;
  logic [1:0]          row_jitter_i = '0;
  logic                done_o;
  logic [TexW-1:0]     texture_col_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  radial_texture_column_mapper_top #(.MAX_DIM(MaxDim)) uut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the configuration registers, as the block holds them.
  logic [DimW-1:0]  sh_width;
  logic [DimW-1:0]  sh_height;
  logic [TileW-1:0] sh_tiling;
  logic [OffW-1:0]  sh_offset;
  logic             sh_noise;

  tex_col_board board = new();
  int               idle_pct;
  int               stall_cycles = 0;
  bit               failed;

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    board.mismatches++;
  endtask

  // Bit-serial integer square root of a 64-bit value.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Moves one coordinate by the jitter code, wrapping at the screen edge.
  // Code three behaves as plus one.
  function automatic longint jitter_coord(input longint k, input longint n,
                                          input logic [1:0] code);
    if (!sh_noise) return k;
    if (code == JitMinus) return (k == 0) ? n - 1 : k - 1;
    if (code == JitHold) return k;
    return (k == n - 1) ? 0 : k + 1;
  endfunction

  // Computes the texture column that one pixel beat must produce.
  function automatic int unsigned texture_column(input logic [CoordW-1:0] pc,
      input logic [CoordW-1:0] pr, input logic [1:0] cj, input logic [1:0] rj);
    longint unsigned w, h, sq, rq, num, idx, half;
    longint          c, r, dx, dy;
    w = (sh_width > MaxDim) ? MaxDim : sh_width;
    h = (sh_height > MaxDim) ? MaxDim : sh_height;
    if (h == 0) h = 1;
    c = jitter_coord(longint'(pc), longint'(w), cj);
    r = jitter_coord(longint'(pr), longint'(h), rj);
    dx = 2 * c - longint'(w);
    dy = 2 * r - longint'(h);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = dx * dx + dy * dy;
    rq = int_sqrt(sq << 16);
    num = w * sh_tiling * rq * 5 + sh_offset * 16 * h;
    idx = num / (h << 12);
    half = w >> 1;
    if (half == 0) idx = 0;
    else if (idx > half) idx = ((idx - 1) % half) + 1;
    return int'(idx & 64'hFFF);
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_SCREEN_WIDTH:  sh_width  = value[DimW-1:0];
      CFG_SCREEN_HEIGHT: sh_height = value[DimW-1:0];
      CFG_TILING_FACTOR: sh_tiling = value[TileW-1:0];
      CFG_OFFSET_Q8:     sh_offset = value[OffW-1:0];
      default:           sh_noise  = value[0];
    endcase
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h,
      input int unsigned t, input int unsigned o, input int unsigned n);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    write_reg(CFG_TILING_FACTOR, t);
    write_reg(CFG_OFFSET_Q8, o);
    write_reg(CFG_NOISE_ENABLE, n);
  endtask

  // Sends one pixel beat, after a random idle gap, and notes its column.
  // The beat is accepted at the edge where start_i is high and busy_o low.
  task automatic send_pixel(input logic [CoordW-1:0] pc, input logic [CoordW-1:0] pr,
                            input logic [1:0] cj, input logic [1:0] rj);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    pixel_col_i  <= pc;
    pixel_row_i  <= pr;
    col_jitter_i <= cj;
    row_jitter_i <= rj;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note_pixel(texture_column(pc, pr, cj, rj));
  endtask

  // Lowers start and waits for every pending column, plus a margin so the
  // pipeline is empty before registers change.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_cols.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // Pixels mostly within the screen bounds, with some anywhere in the field.
  task automatic random_pixels(input int count);
    logic [CoordW-1:0] pc, pr;
    int unsigned w, h;
    for (int i = 0; i < count; i++) begin
      w = (sh_width == 0) ? 1 : sh_width;
      h = (sh_height == 0) ? 1 : sh_height;
      if ($urandom_range(9) < 2) begin
        pc = CoordW'($urandom);
        pr = CoordW'($urandom);
      end else begin
        pc = CoordW'($urandom_range(w > 4096 ? 4095 : w - 1));
        pr = CoordW'($urandom_range(h > 4096 ? 4095 : h - 1));
      end
      send_pixel(pc, pr, 2'($urandom), 2'($urandom));
    end
  endtask

  // Result checker: done_o is sampled at the edge that ends its cycle.
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && done_o) begin
      msg = board.check_col(texture_col_o);
      if (msg != "") report_mismatch(msg);
    end
  end

  // Watchdog: ends the run after too many cycles without accepted beats, results or register writes.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_we_i) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > StallMax) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    idle_pct = 0;
    sh_width = 13'd640;
    sh_height = 13'd480;
    sh_tiling = 8'd1;
    sh_offset = '0;
    sh_noise = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats on reset settings: corners, centre and field extremes.
    send_pixel(12'd0, 12'd0, 2'd1, 2'd1);
    send_pixel(12'd639, 12'd479, 2'd0, 2'd2);
    send_pixel(12'd320, 12'd240, 2'd3, 2'd3);
    send_pixel(12'hFFF, 12'hFFF, 2'd2, 2'd0);
    drain();
    // Jitter on: wrapping at each edge, code three and off-screen coordinates.
    write_reg(CFG_NOISE_ENABLE, 1);
    send_pixel(12'd0, 12'd0, 2'd0, 2'd0);
    send_pixel(12'd639, 12'd479, 2'd2, 2'd2);
    send_pixel(12'd639, 12'd479, 2'd3, 2'd3);
    send_pixel(12'hFFF, 12'hFFF, 2'd0, 2'd2);
    send_pixel(12'd700, 12'd10, 2'd2, 2'd1);
    drain();
    // Oversized dimensions, full tiling and offset.
    set_config(8191, 8191, 255, 1048575, 1);
    send_pixel(12'd0, 12'd0, 2'd0, 2'd0);
    send_pixel(12'hFFF, 12'hFFF, 2'd2, 2'd2);
    send_pixel(12'd2048, 12'd2048, 2'd1, 2'd1);
    drain();
    // Zero width and height: minus-one jitter moves pixel column zero to -1.
    set_config(0, 0, 7, 300, 1);
    send_pixel(12'd0, 12'd0, 2'd0, 2'd0);
    send_pixel(12'd5, 12'd9, 2'd2, 2'd1);
    drain();
    // Width one, height one, tiling zero.
    set_config(1, 1, 0, 1000, 1);
    send_pixel(12'd0, 12'd0, 2'd0, 2'd2);
    send_pixel(12'd3, 12'd1, 2'd1, 2'd0);
    drain();
    set_config(2, 4096, 255, 0, 0);
    send_pixel(12'd1, 12'd4095, 2'd0, 2'd0);
    send_pixel(12'd0, 12'd0, 2'd1, 2'd1);
    drain();

    // Random part across settings and idle phases.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 87;
        2: idle_pct = 15;
        default: idle_pct = 50;
      endcase
      if (ph == 0) set_config(640, 480, 1, 0, 1);
      else if (ph == 1) set_config(4096, 4096, 255, 1048575, 1);
      else if (ph == 2) set_config(2, 1, 0, 0, 0);
      else set_config($urandom_range(8191), $urandom_range(8191), $urandom_range(255),
                      $urandom_range(1048575), $urandom_range(1));
      random_pixels(85);
      drain();
    end

    failed = board.mismatches != 0 || board.pending_cols.size() != 0;
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

`default_nettype wire
